// ===== hw/rtl/btpf_pkg.sv =====
// Shared types, constants and helpers for the background tile pixel fetcher.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package btpf_pkg;

	// Default sizes for the top-level parameters
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int LINE_WIDTH_DEF  = 160;

	// Register file layout: six 32-bit registers at 4-byte spacing
	localparam int REG_COUNT = 6;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// Video memory bases
	localparam logic [15:0] MAP_BASE_LO  = 16'h9800;
	localparam logic [15:0] MAP_BASE_HI  = 16'h9C00;
	localparam logic [15:0] TILE_BASE_U  = 16'h8000;
	localparam logic [15:0] TILE_BASE_S  = 16'h8800;
	localparam logic [7:0]  TILE_ID_BIAS = 8'd128;

	// A tile row is eight pixels; a push needs room for a full row
	localparam int TILE_PIXELS = 8;

	// Register reset values
	localparam logic [7:0] PALETTE_RST = 8'd252;

	typedef enum logic [2:0] {
		PH_TILE,
		PH_LOW,
		PH_HIGH,
		PH_IDLE,
		PH_PUSH
	} phase_t;

	typedef enum logic [1:0] {
		TGT_NONE,
		TGT_TILE,
		TGT_LOW,
		TGT_HIGH
	} target_t;

	typedef enum logic [1:0] {
		CMD_LINE,
		CMD_DOT,
		CMD_FETCH
	} cmd_kind_t;

	typedef enum logic [2:0] {
		REG_BG_ENABLE,
		REG_BG_MAP_HIGH,
		REG_TILE_DATA_UNSIGNED,
		REG_SCROLL_X,
		REG_SCROLL_Y,
		REG_BG_PALETTE
	} reg_idx_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] line_number;
		logic       fetch_dot;
		logic [7:0] mem_data;
	} item_t;

	typedef struct packed {
		logic        mem_req;
		logic [15:0] mem_addr;
		logic        pixel_valid;
		logic [7:0]  pixel_x;
		logic [1:0]  pixel_shade;
	} result_t;

	// Classified dot handed from the front to the back
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] line_number;
		logic [7:0] mem_data;
	} cmd_t;

	typedef struct packed {
		logic       bg_enable;
		logic       bg_map_high;
		logic       tile_data_unsigned;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] bg_palette;
	} cfg_t;

	function automatic logic [1:0] palette_shade(input logic [7:0] pal, input logic [1:0] idx);
		logic [1:0] s;
		case (idx)
			2'd0:    s = pal[1:0];
			2'd1:    s = pal[3:2];
			2'd2:    s = pal[5:4];
			default: s = pal[7:6];
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/btpf_regs.sv =====
// APB-style configuration registers for the background fetcher.
// Depends on btpf_pkg (cfg_t, register indexes).
`default_nettype none

module btpf_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [btpf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [btpf_pkg::DATA_W-1:0] pwdata,
	output logic      [btpf_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output btpf_pkg::cfg_t                   cfg
);
	import btpf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bg_enable          <= 1'b1;
			cfg_q.bg_map_high        <= 1'b0;
			cfg_q.tile_data_unsigned <= 1'b1;
			cfg_q.scroll_x           <= 8'd0;
			cfg_q.scroll_y           <= 8'd0;
			cfg_q.bg_palette         <= PALETTE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_BG_ENABLE:          cfg_q.bg_enable          <= pwdata[0];
				REG_BG_MAP_HIGH:        cfg_q.bg_map_high        <= pwdata[0];
				REG_TILE_DATA_UNSIGNED: cfg_q.tile_data_unsigned <= pwdata[0];
				REG_SCROLL_X:           cfg_q.scroll_x           <= pwdata[7:0];
				REG_SCROLL_Y:           cfg_q.scroll_y           <= pwdata[7:0];
				REG_BG_PALETTE:         cfg_q.bg_palette         <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_BG_ENABLE:          prdata[0]   = cfg_q.bg_enable;
			REG_BG_MAP_HIGH:        prdata[0]   = cfg_q.bg_map_high;
			REG_TILE_DATA_UNSIGNED: prdata[0]   = cfg_q.tile_data_unsigned;
			REG_SCROLL_X:           prdata[7:0] = cfg_q.scroll_x;
			REG_SCROLL_Y:           prdata[7:0] = cfg_q.scroll_y;
			REG_BG_PALETTE:         prdata[7:0] = cfg_q.bg_palette;
			default:                prdata      = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/btpf_front.sv =====
// Front end: accepts dots, classifies them and holds them in a two-entry queue.
// Depends on btpf_pkg (item_t, cmd_t).
`default_nettype none

module btpf_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire btpf_pkg::item_t item,
	output logic                 cmd_valid,
	output btpf_pkg::cmd_t       cmd,
	input  wire logic            cmd_take
);
	import btpf_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr;
	cmd_t       cls;

	// line start, fetching dot or plain dot
	always_comb begin
		cls.line_number = item.line_number;
		cls.mem_data    = item.mem_data;
		if (!item.mode) begin
			cls.kind = CMD_LINE;
		end else if (item.fetch_dot) begin
			cls.kind = CMD_FETCH;
		end else begin
			cls.kind = CMD_DOT;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign wr        = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, cmd_take};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/btpf_back.sv =====
// Back end: tile fetch sequencer, pixel queue and pixel output, one dot a cycle while the result queue has space.
// Depends on btpf_pkg (cmd_t, cfg_t, result_t, phase and target codes).
`default_nettype none

module btpf_back #(
	parameter int QUEUE_DEPTH = btpf_pkg::QUEUE_DEPTH_DEF,
	parameter int LINE_WIDTH  = btpf_pkg::LINE_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire btpf_pkg::cfg_t   cfg,
	input  wire logic             cmd_valid,
	input  wire btpf_pkg::cmd_t   cmd,
	output logic                  cmd_take,
	input  wire logic             res_space,
	output btpf_pkg::result_t     res
);
	import btpf_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(LINE_WIDTH + 1);
	localparam int PW = IW + 2;

	phase_t        phase_q, phase_d;
	target_t       target_q, target_d;
	logic [7:0]    tile_q, lo_q, hi_q;
	logic [7:0]    tile_cur, lo_cur, hi_cur;
	logic [7:0]    fcol_q, fcol_d;
	logic [7:0]    lcol_q;
	logic [SW-1:0] sent_q;
	logic [CW-1:0] count_q, count_mid;
	logic [IW-1:0] head_q, head_d;
	logic [1:0]    pq_q [QUEUE_DEPTH];

	logic          fire, dot, fetch;
	logic [7:0]    y, x, tile_id;
	logic [15:0]   map_addr, row_addr;
	logic          do_push, do_pop, emit;
	logic [1:0]    pop_idx;
	logic [IW-1:0] wr_idx [TILE_PIXELS];
	logic [1:0]    wr_val [TILE_PIXELS];
	logic [PW-1:0] slot;

	assign fire     = cmd_valid && res_space;
	assign cmd_take = fire;
	assign dot      = (cmd.kind != CMD_LINE);
	assign fetch    = (cmd.kind == CMD_FETCH);

	always_comb begin
		// answer to last dot's request
		tile_cur = tile_q;
		lo_cur   = lo_q;
		hi_cur   = hi_q;
		case (target_q)
			TGT_TILE: tile_cur = cmd.mem_data;
			TGT_LOW:  lo_cur   = cmd.mem_data;
			TGT_HIGH: hi_cur   = cmd.mem_data;
			default: ;
		endcase

		y        = cmd.line_number + cfg.scroll_y;
		x        = fcol_q + cfg.scroll_x;
		map_addr = (cfg.bg_map_high ? MAP_BASE_HI : MAP_BASE_LO) + {6'd0, y[7:3], x[7:3]};
		tile_id  = cfg.tile_data_unsigned ? tile_cur : tile_cur + TILE_ID_BIAS;
		row_addr = (cfg.tile_data_unsigned ? TILE_BASE_U : TILE_BASE_S)
			+ {4'd0, tile_id, 4'd0} + {12'd0, y[2:0], 1'b0};

		phase_d  = phase_q;
		target_d = TGT_NONE;
		fcol_d   = fcol_q;
		do_push  = 1'b0;
		res      = '0;

		if (fetch) begin
			case (phase_q)
				PH_TILE: begin
					res.mem_req  = 1'b1;
					res.mem_addr = map_addr;
					target_d     = TGT_TILE;
					fcol_d       = fcol_q + 8'(TILE_PIXELS);
					phase_d      = PH_LOW;
				end
				PH_LOW: begin
					res.mem_req  = 1'b1;
					res.mem_addr = row_addr;
					target_d     = TGT_LOW;
					phase_d      = PH_HIGH;
				end
				PH_HIGH: begin
					// row address is even, so +1 is a bit set
					res.mem_req  = 1'b1;
					res.mem_addr = {row_addr[15:1], 1'b1};
					target_d     = TGT_HIGH;
					phase_d      = PH_IDLE;
				end
				PH_IDLE: begin
					phase_d = PH_PUSH;
				end
				PH_PUSH: begin
					if (count_q <= CW'(TILE_PIXELS)) begin
						do_push = 1'b1;
						phase_d = PH_TILE;
					end
				end
				default: begin
					phase_d = PH_TILE;
				end
			endcase
		end

		// push slots: on a push, head + count + i stays below twice the depth
		for (int i = 0; i < TILE_PIXELS; i++) begin
			slot = PW'(head_q) + PW'(count_q) + PW'(i);
			if (slot >= PW'(QUEUE_DEPTH)) begin
				slot = slot - PW'(QUEUE_DEPTH);
			end
			wr_idx[i] = slot[IW-1:0];
			wr_val[i] = cfg.bg_enable ? {hi_cur[TILE_PIXELS-1-i], lo_cur[TILE_PIXELS-1-i]} : 2'd0;
		end

		count_mid = do_push ? count_q + CW'(TILE_PIXELS) : count_q;
		// a pop needs at least one entry from before this push, so head is never new
		do_pop    = dot && (count_mid > CW'(TILE_PIXELS));
		pop_idx   = pq_q[head_q];
		emit      = do_pop && (lcol_q >= {5'd0, cfg.scroll_x[2:0]})
			&& (sent_q < SW'(LINE_WIDTH));
		head_d    = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

		if (emit) begin
			res.pixel_valid = 1'b1;
			res.pixel_x     = 8'(sent_q);
			res.pixel_shade = palette_shade(cfg.bg_palette, pop_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && dot && do_push) begin
			for (int i = 0; i < TILE_PIXELS; i++) begin
				pq_q[wr_idx[i]] <= wr_val[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TILE;
			target_q <= TGT_NONE;
			tile_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			fcol_q   <= '0;
			lcol_q   <= '0;
			sent_q   <= '0;
			count_q  <= '0;
			head_q   <= '0;
		end else if (fire) begin
			if (!dot) begin
				phase_q  <= PH_TILE;
				target_q <= TGT_NONE;
				tile_q   <= '0;
				lo_q     <= '0;
				hi_q     <= '0;
				fcol_q   <= '0;
				lcol_q   <= '0;
				sent_q   <= '0;
				count_q  <= '0;
				head_q   <= '0;
			end else begin
				phase_q  <= phase_d;
				target_q <= target_d;
				tile_q   <= tile_cur;
				lo_q     <= lo_cur;
				hi_q     <= hi_cur;
				fcol_q   <= fcol_d;
				count_q  <= count_mid - CW'(do_pop);
				if (do_pop) begin
					head_q <= head_d;
					if (lcol_q != 8'hFF) begin
						lcol_q <= lcol_q + 8'd1;
					end
				end
				if (emit) begin
					sent_q <= sent_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/btpf_res_fifo.sv =====
// Two-entry result queue between the back end and the result port.
// Depends on btpf_pkg (result_t).
`default_nettype none

module btpf_res_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire btpf_pkg::result_t wr_data,
	output logic                   space,
	output logic                   empty,
	input  wire logic              pop,
	output btpf_pkg::result_t      result
);
	import btpf_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign space  = (cnt_q != 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd     = pop && !empty;
	assign result = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/background_tile_pixel_fetcher_top.sv =====
// Top level of the background tile pixel fetcher: registers, front, back, result queue.
// Depends on btpf_pkg, btpf_regs, btpf_front, btpf_back and btpf_res_fifo.
//
//   channel   handshake          payload           transfer when
//   -------   ----------------   ---------------   ---------------------------------
//   dots      push / full        item (item_t)     push && !full
//   results   pop / empty        result (result_t) pop && !empty
//   config    psel/penable/...   pwdata, paddr     psel && penable && pwrite && pready
//
// One dot per clock sustained while results are popped. Each dot produces exactly one
// result; a dot is registered in the front queue, taken by the back end once the result
// queue has space, and its result is registered there. The fetch sequencer and pixel
// queue update once per dot, so the back end is the rate-setting unit at one dot a cycle.
// Both side queues hold two entries, so full only rises when the result side stalls.
// Reset clears all queues and restores register defaults; no clearing pass is needed.
`default_nettype none

module background_tile_pixel_fetcher_top #(
	parameter int QUEUE_DEPTH = btpf_pkg::QUEUE_DEPTH_DEF,
	parameter int LINE_WIDTH  = btpf_pkg::LINE_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// dot channel
	input  wire logic                        push,
	output logic                             full,
	input  wire btpf_pkg::item_t             item,
	// result channel
	output logic                             empty,
	input  wire logic                        pop,
	output btpf_pkg::result_t                result,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [btpf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [btpf_pkg::DATA_W-1:0] pwdata,
	output logic      [btpf_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);
	import btpf_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_take;
	logic    res_space;
	result_t res;

	// register block; the user must write it only while no dot is in flight, the block does not enforce this
	btpf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: takes dots, tags line starts and fetch dots
	btpf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// back: fetch sequencer and pixel queue, one dot per transfer into the result queue
	btpf_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.LINE_WIDTH  (LINE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_space (res_space),
		.res       (res)
	);

	// result queue decouples the back end from result-side stalls
	btpf_res_fifo u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_take),
		.wr_data (res),
		.space   (res_space),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for background_tile_pixel_fetcher_top: random video dots in, results out.
// Depends on btpf_pkg and the RTL top; results are predicted by a fetcher model kept in this file.
module tb_top;
	import btpf_pkg::*;

	localparam int QDEPTH       = QUEUE_DEPTH_DEF;
	localparam int LINE_PIXELS  = LINE_WIDTH_DEF;
	localparam int RANDOM_DOTS  = 600;
	localparam int LONG_LINE    = 300;	// long enough to finish the line and pin line_column
	localparam int HOLD_CYCLES  = 80;
	localparam int RUN_LIMIT    = 4_000_000;
	// register slot past the end of the map, writes must be dropped
	localparam logic [2:0] REG_UNMAPPED = 3'd6;

	typedef enum int {
		FETCH_EVERY,
		FETCH_ALTERNATE,
		FETCH_RANDOM,
		LINE_NOISY
	} line_style_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// DUT hookup
	logic                push = 1'b0;
	logic                full;
	item_t               dot = '0;
	logic                empty;
	logic                pop = 1'b0;
	result_t             res;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	background_tile_pixel_fetcher_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (dot),
		.empty   (empty),
		.pop     (pop),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Register mirror, starts at the reset values.
	logic       cfg_en     = 1'b1;
	logic       cfg_map_hi = 1'b0;
	logic       cfg_tdu    = 1'b1;
	logic [7:0] cfg_sx     = 8'd0;
	logic [7:0] cfg_sy     = 8'd0;
	logic [7:0] cfg_pal    = PALETTE_RST;

	// Fetcher and pixel queue state of the predictor.
	phase_t     fph   = PH_TILE;
	target_t    rtgt  = TGT_NONE;
	logic [7:0] tile_id = '0;
	logic [7:0] plo     = '0;
	logic [7:0] phi     = '0;
	logic [7:0] fcol    = '0;
	logic [7:0] lcol    = '0;
	int         sent    = 0;
	logic [1:0] pq [QDEPTH] = '{default: 2'd0};
	int         qcnt  = 0;
	logic [3:0] qhead = '0;

	// Stimulus and scoreboard storage.
	item_t   dot_backlog[$];
	result_t dot_results_due[$];
	int      n_filled   = 0;	// dots queued by the sequence
	int      n_checked  = 0;	// results matched against a prediction
	int      n_pixels   = 0;
	int      n_bad      = 0;
	int      n_lines    = 0;
	int      n_settings = 0;
	logic    dot_taken  = 1'b0;

	// Sender burst shaping and receiver stall pattern.
	int          burst_left  = 0;
	int          gap_left    = 0;
	logic        hold_go     = 1'b0;
	logic        hold_done   = 1'b0;
	int          hold_cycles = 0;
	logic [15:0] stall_pat   = 16'hFFFF;
	logic [5:0]  pat_age     = '0;

	// ------------------------------------------------------------------
	// Predictor: one dot in, one result out, state carried across dots.
	// ------------------------------------------------------------------
	task automatic clear_line();
		fph = PH_TILE;
		rtgt = TGT_NONE;
		tile_id = '0;
		plo = '0;
		phi = '0;
		fcol = '0;
		lcol = '0;
		sent = 0;
		qcnt = 0;
		qhead = '0;
	endtask

	task automatic run_fetcher_dot(input item_t d, output result_t r);
		logic [7:0]  y;
		logic [7:0]  x;
		logic [7:0]  tid;
		logic [15:0] tbase;
		logic [1:0]  ci;
		int          k;
		r = '0;
		if (!d.mode) begin
			clear_line();
		end else begin
			// answer to last dot's request lands first
			case (rtgt)
				TGT_TILE: tile_id = d.mem_data;
				TGT_LOW:  plo = d.mem_data;
				TGT_HIGH: phi = d.mem_data;
				default: ;
			endcase
			rtgt = TGT_NONE;

			y = d.line_number + cfg_sy;	// map rows wrap at 256 lines
			tid = cfg_tdu ? tile_id : tile_id + TILE_ID_BIAS;
			tbase = (cfg_tdu ? TILE_BASE_U : TILE_BASE_S) + {4'b0, tid, 4'b0}
				+ {12'b0, y[2:0], 1'b0};

			if (d.fetch_dot) begin
				case (fph)
					PH_TILE: begin
						x = fcol + cfg_sx;
						r.mem_req = 1'b1;
						r.mem_addr = (cfg_map_hi ? MAP_BASE_HI : MAP_BASE_LO)
							+ {6'b0, y[7:3], 5'b0} + {11'b0, x[7:3]};
						rtgt = TGT_TILE;
						fcol = fcol + 8'd8;
						fph = PH_LOW;
					end
					PH_LOW: begin
						r.mem_req = 1'b1;
						r.mem_addr = tbase;
						rtgt = TGT_LOW;
						fph = PH_HIGH;
					end
					PH_HIGH: begin
						r.mem_req = 1'b1;
						r.mem_addr = tbase + 16'd1;
						rtgt = TGT_HIGH;
						fph = PH_IDLE;
					end
					PH_IDLE: fph = PH_PUSH;
					PH_PUSH: begin
						// stalls here while the queue cannot take a whole row
						if (qcnt <= TILE_PIXELS) begin
							for (k = 7; k >= 0; k--) begin
								ci = cfg_en ? {phi[k], plo[k]} : 2'd0;
								pq[(int'(qhead) + qcnt) % QDEPTH] = ci;
								qcnt++;
							end
							fph = PH_TILE;
						end
					end
					default: fph = PH_TILE;
				endcase
			end

			// shift one pixel out once more than a row is buffered
			if (qcnt > TILE_PIXELS) begin
				ci = pq[qhead];
				qhead = qhead + 4'd1;
				qcnt--;
				if (lcol >= {5'b0, cfg_sx[2:0]} && sent < LINE_PIXELS) begin
					r.pixel_valid = 1'b1;
					r.pixel_x = 8'(sent);
					r.pixel_shade = cfg_pal[{ci, 1'b0} +: 2];
					sent++;
				end
				if (lcol < 8'd255)
					lcol = lcol + 8'd1;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: dot transfers feed the predictor, result transfers are checked.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		result_t pred;
		int      errs;
		errs = 0;
		if (arst_n) begin
			dot_taken <= push && !full;
			// a result popped now belongs to a dot taken at an earlier edge
			if (pop && !empty) begin
				if (dot_results_due.size() == 0) begin
					$error("result transfer with nothing expected: %h", res);
					errs++;
				end else begin
					want = dot_results_due.pop_front();
					if (res.mem_req !== want.mem_req) begin
						$error("mem_req: expected %0d, got %0d", want.mem_req, res.mem_req);
						errs++;
					end
					if (res.mem_addr !== want.mem_addr) begin
						$error("mem_addr: expected %h, got %h", want.mem_addr, res.mem_addr);
						errs++;
					end
					if (res.pixel_valid !== want.pixel_valid) begin
						$error("pixel_valid: expected %0d, got %0d",
							want.pixel_valid, res.pixel_valid);
						errs++;
					end
					if (res.pixel_x !== want.pixel_x) begin
						$error("pixel_x: expected %0d, got %0d", want.pixel_x, res.pixel_x);
						errs++;
					end
					if (res.pixel_shade !== want.pixel_shade) begin
						$error("pixel_shade: expected %0d, got %0d",
							want.pixel_shade, res.pixel_shade);
						errs++;
					end
					n_checked <= n_checked + 1;
					n_pixels <= n_pixels + int'(res.pixel_valid);
				end
			end
			if (push && !full) begin
				run_fetcher_dot(dot, pred);
				dot_results_due.push_back(pred);
			end
			n_bad <= n_bad + errs;
		end
	end

	// ------------------------------------------------------------------
	// Driver: offers backlog dots in bursts; holds a dot until its transfer.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		item_t next_dot;
		if (!push || dot_taken) begin
			if (gap_left > 0) begin
				push <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (dot_backlog.size() > 0) begin
				next_dot = dot_backlog.pop_front();
				push <= 1'b1;
				dot <= next_dot;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 48);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: one long hold-off on request, otherwise a rotating stall mask.
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			pop <= 1'b0;
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			if (pat_age == 6'd63) begin
				// some windows never stall; bit 0 keeps the worst case moving
				stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
					: (16'($urandom) | 16'($urandom) | 16'h0001);
			end
			pat_age <= pat_age + 6'd1;
			pop <= stall_pat[pat_age[3:0]];
		end
	end

	// ------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BG_ENABLE:          cfg_en = val[0];
			REG_BG_MAP_HIGH:        cfg_map_hi = val[0];
			REG_TILE_DATA_UNSIGNED: cfg_tdu = val[0];
			REG_SCROLL_X:           cfg_sx = val[7:0];
			REG_SCROLL_Y:           cfg_sy = val[7:0];
			REG_BG_PALETTE:         cfg_pal = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic en, input logic map_hi, input logic tdu,
		input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] pal);
		write_reg(REG_BG_ENABLE, DATA_W'(en));
		write_reg(REG_BG_MAP_HIGH, DATA_W'(map_hi));
		write_reg(REG_TILE_DATA_UNSIGNED, DATA_W'(tdu));
		write_reg(REG_SCROLL_X, DATA_W'(sx));
		write_reg(REG_SCROLL_Y, DATA_W'(sy));
		write_reg(REG_BG_PALETTE, DATA_W'(pal));
		n_settings++;
	endtask

	task automatic queue_dot(input logic mode, input logic [7:0] ln, input logic fdot,
		input logic [7:0] data);
		item_t d;
		d.mode = mode;
		d.line_number = ln;
		d.fetch_dot = fdot;
		d.mem_data = data;
		dot_backlog.push_back(d);
		n_filled++;
	endtask

	// A line start followed by dots; noisy lines break the sequence at random.
	task automatic queue_line(input int n_dots, input line_style_t style);
		logic [7:0] ln;
		logic       fdot;
		logic       mode;
		int         i;
		ln = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(154, 255))
			: 8'($urandom_range(0, 153));
		queue_dot(1'b0, ln, 1'($urandom), 8'($urandom));
		for (i = 0; i < n_dots; i++) begin
			mode = 1'b1;
			case (style)
				FETCH_EVERY:     fdot = 1'b1;
				FETCH_ALTERNATE: fdot = 1'(i);
				FETCH_RANDOM:    fdot = ($urandom_range(0, 3) != 0);
				default: begin
					fdot = 1'($urandom);
					mode = ($urandom_range(0, 15) != 0);
					ln = 8'($urandom);
				end
			endcase
			queue_dot(mode, ln, fdot, 8'($urandom));
		end
		n_lines++;
	endtask

	// Sender pause: nothing new until every predicted result has been checked.
	task automatic wait_drained();
		while (n_checked != n_filled)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int          p;
		int          k;
		int          random_dots;
		line_style_t style;
		int          len;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed line at reset settings: bottom line number for the last map row,
		// a stray answer with nothing pending, full/empty plane bytes, a push that
		// has to wait on a full pixel queue, then a line start mid-stream.
		@(posedge clk);
		queue_dot(1'b0, 8'd255, 1'b1, 8'hFF);
		queue_dot(1'b1, 8'd255, 1'b0, 8'hA5);
		for (k = 0; k < 18; k++)
			queue_dot(1'b1, 8'd255, 1'b1, k[0] ? 8'h00 : 8'hFF);
		queue_dot(1'b0, 8'd0, 1'b0, 8'h00);
		queue_dot(1'b1, 8'd0, 1'b1, 8'h5A);
		n_lines += 2;
		wait_drained();

		// unmapped slot, must leave every register alone
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);

		random_dots = 0;
		p = 0;
		while (p < 6 || random_dots < RANDOM_DOTS) begin
			case (p)
				0: set_config(1'b0, 1'b1, 1'b0, 8'd255, 8'd255, 8'h00);
				1: set_config(1'b1, 1'b0, 1'b1, 8'd0, 8'd0, 8'hFF);
				2: set_config(1'b1, 1'b1, 1'b0, 8'd7, 8'd8, 8'h1B);
				default: set_config($urandom_range(0, 4) != 0, 1'($urandom), 1'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			@(posedge clk);

			if (p == 1) begin
				// full line: runs past the last visible pixel and pins line_column
				queue_line(LONG_LINE, FETCH_EVERY);
				random_dots += LONG_LINE + 1;
			end
			if (p == 2) begin
				// receiver goes quiet while the sender keeps offering: full must rise
				hold_go <= 1'b1;
				queue_line(120, FETCH_EVERY);
				random_dots += 121;
			end

			for (k = $urandom_range(1, 2); k > 0; k--) begin
				style = ($urandom_range(0, 7) == 0) ? LINE_NOISY
					: line_style_t'($urandom_range(0, 2));
				len = $urandom_range(4, 40);
				queue_line(len, style);
				random_dots += len + 1;
			end
			wait_drained();
			p++;
		end

		wait_drained();
		repeat (8) @(negedge clk);

		$display("Covered %0d lines, %0d dots, %0d register settings",
			n_lines, n_filled, n_settings);
		$display("Checked %0d results, %0d of them visible pixels", n_checked, n_pixels);
		if (n_bad == 0 && dot_results_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (dot_results_due.size() != 0)
				$error("%0d expected results never arrived", dot_results_due.size());
			$display("Mismatches found");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#RUN_LIMIT;
		$display("Mismatches found");
		$finish;
	end

endmodule
